// ===== hw/rtl/vdi_pkg.sv =====
// Shared widths, constants and float compare helpers for the vertex dedup indexer.
package vdi_pkg;

  localparam int COORD_W        = 32;
  localparam int VTX_W          = 3 * COORD_W;
  localparam int VERTEX_INDEX_W = 10;
  localparam int UNIQUE_COUNT_W = 11;
  localparam int IN_TDATA_W     = 96;
  localparam int OUT_TDATA_W    = 24;
  localparam int OUT_TUSER_W    = 2;
  localparam int EPOCH_W        = 8;

  localparam logic [COORD_W-1:0] MAG_MASK = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] INF_BITS = 32'h7F80_0000;

  localparam logic [EPOCH_W-1:0] EPOCH_SWEPT = '0;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

  function automatic logic coord_is_nan(input logic [COORD_W-1:0] a);
    return (a & MAG_MASK) > INF_BITS;
  endfunction

  function automatic logic coord_equal(input logic [COORD_W-1:0] a,
                                       input logic [COORD_W-1:0] b);
    logic both_zero;
    both_zero = ((a | b) & MAG_MASK) == '0;
    return !coord_is_nan(a) && !coord_is_nan(b) && ((a == b) || both_zero);
  endfunction

  // map -0 onto +0 so equal coordinates hash alike
  function automatic logic [COORD_W-1:0] coord_canon(input logic [COORD_W-1:0] a);
    return ((a & MAG_MASK) == '0) ? '0 : a;
  endfunction

endpackage

// ===== hw/rtl/vertex_dedup_indexer.sv =====
// Vertex dedup indexer: hash table with linear probing in one synchronous memory.
//
// Input channel in_*: in_tdata carries x, y, z float bit patterns, in_tuser the
// first-of-mesh flag, which empties the table before that vertex is looked up.
// Result channel out_*: one transfer per input vertex, in order, with its index,
// the unique count after it, and the is_new / table_full flags in out_tuser.
// Each vertex is hashed to a slot of a table with 2^(clog2(TABLE_DEPTH)+1)
// entries; every probe is one memory read plus one compare.
// out_tvalid rises once the probe that settles a vertex has been compared, each
// further probe adding one read and one compare; the next vertex is taken only
// after the result is loaded, so vertices are handled one at a time. A mesh
// clear bumps an epoch tag stored in each slot; every 255th clear, and every
// reset, runs a sweep that zeros the tags, one slot per cycle over all
// 2^(clog2(TABLE_DEPTH)+1) slots, with in_tready low.
// Reset: synchronous, active low; the sweep starts right after it.
// A stalled receiver holds the result in the output register; the block still
// accepts the next vertex and stops before loading its result until the
// register drains.
module vertex_dedup_indexer
  import vdi_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // x_bits, y_bits, z_bits
  input  logic                   in_tuser,   // first_of_mesh
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // vertex_index, unique_count, pad
  output logic [OUT_TUSER_W-1:0] out_tuser   // is_new, table_full
);

  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int SLOT_AW = IDX_W + 1;
  localparam int SLOTS   = 1 << SLOT_AW;
  localparam int WORD_W  = EPOCH_W + IDX_W + VTX_W;
  localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(TABLE_DEPTH);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_CHECK} state_t;

  logic [WORD_W-1:0] slot_mem [SLOTS];
  logic [WORD_W-1:0] rd_word_r;

  state_t               state_r,     state_nxt;
  logic [SLOT_AW-1:0]   clr_r,       clr_nxt;
  logic                 resume_r,    resume_nxt;
  logic [EPOCH_W-1:0]   epoch_r,     epoch_nxt;
  logic [CNT_W-1:0]     count_r,     count_nxt;
  logic [SLOT_AW-1:0]   addr_r,      addr_nxt;
  logic [VTX_W-1:0]     vtx_r,       vtx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]     out_idx_r,   out_idx_nxt;
  logic                 out_new_r,   out_new_nxt;
  logic                 out_full_r,  out_full_nxt;
  logic [CNT_W-1:0]     out_cnt_r,   out_cnt_nxt;

  logic                 mem_we;
  logic [SLOT_AW-1:0]   mem_waddr;
  logic [WORD_W-1:0]    mem_wdata;

  logic [EPOCH_W-1:0]   rd_epoch;
  logic [IDX_W-1:0]     rd_idx;
  logic [VTX_W-1:0]     rd_vtx;
  logic                 slot_live;
  logic                 hit;
  logic                 out_free;
  logic [COORD_W-1:0]   canon_x;
  logic [COORD_W-1:0]   canon_y;
  logic [COORD_W-1:0]   canon_z;
  logic [COORD_W-1:0]   mix;
  logic [SLOT_AW-1:0]   hash;
  logic [31:0]          idx_ext;
  logic [31:0]          cnt_ext;

  assign rd_epoch  = rd_word_r[WORD_W-1 -: EPOCH_W];
  assign rd_idx    = rd_word_r[VTX_W +: IDX_W];
  assign rd_vtx    = rd_word_r[VTX_W-1:0];
  assign slot_live = rd_epoch == epoch_r;
  assign hit       = slot_live
                     && coord_equal(rd_vtx[0*COORD_W +: COORD_W], vtx_r[0*COORD_W +: COORD_W])
                     && coord_equal(rd_vtx[1*COORD_W +: COORD_W], vtx_r[1*COORD_W +: COORD_W])
                     && coord_equal(rd_vtx[2*COORD_W +: COORD_W], vtx_r[2*COORD_W +: COORD_W]);
  assign out_free  = !out_valid_r || out_tready;

  assign canon_x = coord_canon(in_tdata[0*COORD_W +: COORD_W]);
  assign canon_y = coord_canon(in_tdata[1*COORD_W +: COORD_W]);
  assign canon_z = coord_canon(in_tdata[2*COORD_W +: COORD_W]);

  always_comb begin
    int i;
    mix = canon_x
        ^ {canon_y[20:0], canon_y[31:21]}
        ^ {canon_z[9:0], canon_z[31:10]};
    hash = '0;
    for (i = 0; i < COORD_W; i++) begin
      hash[i % SLOT_AW] = hash[i % SLOT_AW] ^ mix[i];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    resume_nxt    = resume_r;
    epoch_nxt     = epoch_r;
    count_nxt     = count_r;
    addr_nxt      = addr_r;
    vtx_nxt       = vtx_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_idx_nxt   = out_idx_r;
    out_new_nxt   = out_new_r;
    out_full_nxt  = out_full_r;
    out_cnt_nxt   = out_cnt_r;
    mem_we        = 1'b0;
    mem_waddr     = addr_r;
    mem_wdata     = {epoch_r, count_r[IDX_W-1:0], vtx_r};

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = {EPOCH_SWEPT, {(IDX_W + VTX_W){1'b0}}};
        clr_nxt   = clr_r + 1'b1;
        if (&clr_r) begin
          state_nxt  = resume_r ? S_READ : S_IDLE;
          resume_nxt = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          vtx_nxt   = in_tdata;
          addr_nxt  = hash;
          state_nxt = S_READ;
          if (in_tuser) begin
            count_nxt = '0;
            if (&epoch_r) begin
              epoch_nxt  = EPOCH_FIRST;
              resume_nxt = 1'b1;
              clr_nxt    = '0;
              state_nxt  = S_CLEAR;
            end else begin
              epoch_nxt = epoch_r + 1'b1;
            end
          end
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (slot_live && !hit) begin
          addr_nxt  = addr_r + 1'b1;
          state_nxt = S_READ;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          out_cnt_nxt   = count_r;
          if (hit) begin
            out_idx_nxt  = rd_idx;
            out_new_nxt  = 1'b0;
            out_full_nxt = 1'b0;
          end else if (count_r == COUNT_FULL) begin
            out_idx_nxt  = '0;
            out_new_nxt  = 1'b1;
            out_full_nxt = 1'b1;
          end else begin
            mem_we       = 1'b1;
            out_idx_nxt  = count_r[IDX_W-1:0];
            out_new_nxt  = 1'b1;
            out_full_nxt = 1'b0;
            count_nxt    = count_r + 1'b1;
            out_cnt_nxt  = count_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    rd_word_r <= slot_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      resume_r    <= 1'b0;
      epoch_r     <= EPOCH_FIRST;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      resume_r    <= resume_nxt;
      epoch_r     <= epoch_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    addr_r     <= addr_nxt;
    vtx_r      <= vtx_nxt;
    out_idx_r  <= out_idx_nxt;
    out_new_r  <= out_new_nxt;
    out_full_r <= out_full_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign idx_ext    = 32'(out_idx_r);
  assign cnt_ext    = 32'(out_cnt_r);
  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - VERTEX_INDEX_W - UNIQUE_COUNT_W){1'b0}},
                       cnt_ext[UNIQUE_COUNT_W-1:0], idx_ext[VERTEX_INDEX_W-1:0]};
  assign out_tuser  = {out_full_r, out_new_r};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_FULL)
    else $error("stored count above table depth");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_full_r |-> out_new_r && out_cnt_r == COUNT_FULL && out_idx_r == '0)
    else $error("table_full result without a full table");

  a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
    epoch_r != EPOCH_SWEPT)
    else $error("epoch tag collides with swept slots");

  a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHECK && mem_we |=> count_r == $past(count_r) + 1'b1 && out_new_r)
    else $error("insert without count advance");

endmodule
